// ----- hdl/sttr_pkg.sv -----
// Shared constants and helpers for the switch table target resolver.
package sttr_pkg;

   localparam int DATA_W    = 32;
   localparam int IDENT_W   = 16;
   localparam int COUNT_W   = 11;
   localparam int OP_W      = 2;
   localparam int SLOT_W    = 10;
   localparam int CSR_IDX_W = 2;

   // Request operation codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_PACKED = 2'd1;
   localparam logic [OP_W-1:0] OP_SPARSE = 2'd2;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_IDENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KEY   = 2'd2;

   localparam logic [IDENT_W-1:0] PACKED_IDENT = 16'h0100;
   localparam logic [IDENT_W-1:0] SPARSE_IDENT = 16'h0200;
   localparam logic [DATA_W-1:0]  MISS_OFFSET  = 32'd3;

   // Midpoint of the half-open search window [lo, hix), rounded down
   function automatic logic [COUNT_W-1:0] mid_of(input logic [COUNT_W-1:0] lo,
                                                 input logic [COUNT_W-1:0] hix);
      logic [COUNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hix} - {{COUNT_W{1'b0}}, 1'b1};
      return sum[COUNT_W:1];
   endfunction

endpackage

// ----- hdl/switch_table_target_resolver.sv -----
// Packed and sparse switch table lookup over key and target memories.
// Load request: writes both memories when the slot index is in range, no response.
// Packed lookup: range check in S_PCHK, target read in S_PREAD, response from S_EMIT.
// Sparse lookup: binary search over the keys in S_SCMP, at most 11 probes, then S_EMIT.
// One shared key comparator drives the search, one probe per cycle; req_ready only when idle.
// Reset clears state, rsp_valid, table ident and first key, sets entry count to 1; memory contents stay undefined.
module switch_table_target_resolver #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sttr_pkg::OP_W-1:0]             req_operation,
   input  logic [sttr_pkg::SLOT_W-1:0]           req_slot_index,
   input  logic signed [sttr_pkg::DATA_W-1:0]    req_slot_key,
   input  logic signed [sttr_pkg::DATA_W-1:0]    req_slot_target,
   input  logic signed [sttr_pkg::DATA_W-1:0]    req_test_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sttr_pkg::DATA_W-1:0]    rsp_branch_offset,
   output logic                                  rsp_found,
   output logic                                  rsp_bad_magic,
   input  logic                                  csr_wr_en,
   input  logic [sttr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sttr_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = sttr_pkg::COUNT_W;
   localparam int DW = sttr_pkg::DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PCHK,
      S_PREAD,
      S_SCMP,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [sttr_pkg::IDENT_W-1:0] table_ident_ff, table_ident_in;
   logic [CW-1:0]                entry_count_ff, entry_count_in;
   logic [DW-1:0]                first_key_ff, first_key_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_offset_ff, rsp_offset_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   logic [DW-1:0]        res_offset_ff, res_offset_in;
   logic                 res_found_ff, res_found_in;
   logic                 res_bad_ff, res_bad_in;

   logic signed [DW:0]   diff_ff, diff_in;
   logic signed [DW-1:0] test_ff, test_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hix_ff, hix_in;
   logic [CW-1:0]        mid_ff, mid_in;

   logic [CW-1:0]        live_count;
   logic                 slot_ok;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [DW-1:0]        rd_key;
   logic [DW-1:0]        rd_target;
   logic [CW-1:0]        nlo;
   logic [CW-1:0]        nhix;

   sttr_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_slot_key),
      .rd_addr (ram_raddr),
      .rd_data (rd_key)
   );

   sttr_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_target_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_slot_target),
      .rd_addr (ram_raddr),
      .rd_data (rd_target)
   );

   // Saturate the programmed count to the store depth
   assign live_count = (32'(entry_count_ff) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                                 : entry_count_ff;
   assign slot_ok    = 32'(req_slot_index) < 32'(MAX_ENTRIES);
   assign ram_waddr  = AW'(req_slot_index);

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_branch_offset = rsp_offset_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_bad_magic     = rsp_bad_ff;

   always_comb begin
      state_in       = state_ff;
      table_ident_in = table_ident_ff;
      entry_count_in = entry_count_ff;
      first_key_in   = first_key_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_bad_in     = rsp_bad_ff;
      res_offset_in  = res_offset_ff;
      res_found_in   = res_found_ff;
      res_bad_in     = res_bad_ff;
      diff_in        = diff_ff;
      test_in        = test_ff;
      lo_in          = lo_ff;
      hix_in         = hix_ff;
      mid_in         = mid_ff;
      ram_we         = 1'b0;
      ram_raddr      = '0;
      nlo            = lo_ff;
      nhix           = hix_ff;

      if (csr_wr_en) begin
         case (csr_index)
            sttr_pkg::CSR_TABLE_IDENT: table_ident_in = csr_wdata[sttr_pkg::IDENT_W-1:0];
            sttr_pkg::CSR_ENTRY_COUNT: entry_count_in = csr_wdata[CW-1:0];
            sttr_pkg::CSR_FIRST_KEY:   first_key_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_offset_in = sttr_pkg::MISS_OFFSET;
               res_found_in  = 1'b0;
               res_bad_in    = 1'b0;
               case (req_operation)
                  sttr_pkg::OP_LOAD: begin
                     ram_we = slot_ok;
                  end
                  sttr_pkg::OP_PACKED: begin
                     if (table_ident_ff != sttr_pkg::PACKED_IDENT) begin
                        res_bad_in = 1'b1;
                        state_in   = S_EMIT;
                     end else begin
                        // exact 33-bit difference, no wrap
                        diff_in  = {req_test_value[DW-1], req_test_value}
                                 - {first_key_ff[DW-1], first_key_ff};
                        state_in = S_PCHK;
                     end
                  end
                  sttr_pkg::OP_SPARSE: begin
                     if (table_ident_ff != sttr_pkg::SPARSE_IDENT) begin
                        res_bad_in = 1'b1;
                        state_in   = S_EMIT;
                     end else if (live_count == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        test_in   = req_test_value;
                        lo_in     = '0;
                        hix_in    = live_count;
                        mid_in    = sttr_pkg::mid_of('0, live_count);
                        ram_raddr = AW'(mid_in);
                        state_in  = S_SCMP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_PCHK: begin
            if (!diff_ff[DW] && (diff_ff[DW-1:0] < DW'(live_count))) begin
               ram_raddr = AW'(diff_ff[DW-1:0]);
               state_in  = S_PREAD;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_PREAD: begin
            res_offset_in = rd_target;
            res_found_in  = 1'b1;
            state_in      = S_EMIT;
         end

         S_SCMP: begin
            // narrow the window around the probed key, issue the next probe
            if (test_ff == $signed(rd_key)) begin
               res_offset_in = rd_target;
               res_found_in  = 1'b1;
               state_in      = S_EMIT;
            end else begin
               if (test_ff < $signed(rd_key)) begin
                  nhix = mid_ff;
               end else begin
                  nlo = mid_ff + 1'b1;
               end
               lo_in  = nlo;
               hix_in = nhix;
               if (nlo < nhix) begin
                  mid_in    = sttr_pkg::mid_of(nlo, nhix);
                  ram_raddr = AW'(mid_in);
               end else begin
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = res_offset_ff;
               rsp_found_in  = res_found_ff;
               rsp_bad_in    = res_bad_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         table_ident_ff <= '0;
         entry_count_ff <= CW'(1);
         first_key_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         table_ident_ff <= table_ident_in;
         entry_count_ff <= entry_count_in;
         first_key_ff   <= first_key_in;
      end
      rsp_offset_ff <= rsp_offset_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_bad_ff    <= rsp_bad_in;
      res_offset_ff <= res_offset_in;
      res_found_ff  <= res_found_in;
      res_bad_ff    <= res_bad_in;
      diff_ff       <= diff_in;
      test_ff       <= test_in;
      lo_ff         <= lo_in;
      hix_ff        <= hix_in;
      mid_ff        <= mid_in;
   end

endmodule

// ----- hdl/sttr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sttr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- hdl/sttr_checker.sv -----
// Port-level checks for the switch table target resolver, bound to the top level.
module sttr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [sttr_pkg::OP_W-1:0]          req_operation,
   input logic [sttr_pkg::SLOT_W-1:0]        req_slot_index,
   input logic signed [sttr_pkg::DATA_W-1:0] req_slot_key,
   input logic signed [sttr_pkg::DATA_W-1:0] req_slot_target,
   input logic signed [sttr_pkg::DATA_W-1:0] req_test_value,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [sttr_pkg::DATA_W-1:0] rsp_branch_offset,
   input logic                               rsp_found,
   input logic                               rsp_bad_magic
);

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_operation)
         && $stable(req_slot_index) && $stable(req_slot_key)
         && $stable(req_slot_target) && $stable(req_test_value))
      else $error("request changed while waiting");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_branch_offset)
         && $stable(rsp_found) && $stable(rsp_bad_magic))
      else $error("response changed while stalled");

   a_found_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_bad_magic))
      else $error("found and bad_magic both set");

   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_branch_offset == sttr_pkg::MISS_OFFSET)
      else $error("miss without the instruction length offset");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind switch_table_target_resolver sttr_checker u_sttr_checker (.*);
